// ----- src/stt_pkg.sv -----
// Shared types and constants for the sorted trigger time table.
package stt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned TIME_W      = 64;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W     = 7;
  localparam int unsigned STATUS_W    = 2;

  localparam logic [TIME_W-1:0] SIGN_BIT = {1'b1, {(TIME_W-1){1'b0}}};

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NEG  = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_WB
  } state_e;

  // Word under work: raw new time plus operands as unsigned order keys.
  typedef struct packed {
    logic [TIME_W-1:0] new_time;
    logic [TIME_W-1:0] key_new;
    logic [TIME_W-1:0] key_now;
    logic [TIME_W-1:0] key_last;
  } item_t;

  typedef struct packed {
    logic cmp_en;
    logic ins_en;
  } cell_ctrl_t;

endpackage

// ----- src/stt_cell.sv -----
// One slot of the sorted table: stored time, compare flags and shift path.
module stt_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  stt_pkg::cell_ctrl_t           ctrl_i,
  input  stt_pkg::item_t                item_i,
  input  logic                          valid_i,
  input  logic                          prev_lt_i,
  input  logic                          prev_q_i,
  input  logic [stt_pkg::TIME_W-1:0]    prev_val_i,
  output logic [stt_pkg::TIME_W-1:0]    val_o,
  output logic                          lt_o,
  output logic                          q_o,
  output logic                          eq_o,
  output logic                          first_o,
  output logic [stt_pkg::TIME_W-1:0]    sel_val_o
);

  logic [stt_pkg::TIME_W-1:0] val_q, val_d;
  logic [stt_pkg::TIME_W-1:0] key;
  logic lt_q, lt_d, eq_q, eq_d, q_q, q_d;

  assign key = val_q ^ stt_pkg::SIGN_BIT;

  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    q_d  = q_q;
    if (ctrl_i.cmp_en) begin
      lt_d = valid_i && (key < item_i.key_new);
      eq_d = valid_i && (val_q == item_i.new_time);
      q_d  = valid_i && (key >= item_i.key_now) && (key > item_i.key_last);
    end
  end

  // A slot at or above the insert point takes the new time if its lower
  // neighbor's time is below the new one, else takes the lower neighbor's time.
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins_en && !lt_q) begin
      val_d = prev_lt_i ? item_i.new_time : prev_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
      q_q  <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
      q_q  <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o     = val_q;
  assign lt_o      = lt_q;
  assign q_o       = q_q;
  assign eq_o      = eq_q;
  assign first_o   = q_q && !prev_q_i;
  assign sel_val_o = first_o ? val_q : '0;

endmodule

// ----- src/sorted_trigger_time_table.sv -----
// Top level of the sorted trigger time table: cell row, control and result register.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i/in_ready_o   | opcode, new_time, current_time,
//           |           |                         | last_trigger_time
//   out     | output    | out_valid_o/out_ready_i | status, next_found, next_time,
//           |           |                         | entry_count
//
// Each word passes through accept, a compare step in which every cell compares
// its time with the operands, and a write-back step in which the insert
// shifts the cell row and the result register loads. The next word is accepted
// right after write-back, while the result may still wait in its register.
// Write-back waits while the result register is full and not being taken.
// Reset empties the table; cell contents are not cleared.
module sorted_trigger_time_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            opcode_i,
  input  logic signed [stt_pkg::TIME_W-1:0] new_time_i,
  input  logic signed [stt_pkg::TIME_W-1:0] current_time_i,
  input  logic signed [stt_pkg::TIME_W-1:0] last_trigger_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [stt_pkg::STATUS_W-1:0]    status_o,
  output logic                            next_found_o,
  output logic signed [stt_pkg::TIME_W-1:0] next_time_o,
  output logic [stt_pkg::ENTRY_W-1:0]     entry_count_o
);

  localparam int unsigned D = stt_pkg::TABLE_DEPTH;

  stt_pkg::state_e state_q, state_d;
  stt_pkg::item_t  item_q;
  logic            opcode_q;
  logic [stt_pkg::CNT_W-1:0] count_q, count_d;

  logic                           out_valid_q;
  logic [stt_pkg::STATUS_W-1:0]   status_q, status_d;
  logic                           found_q;
  logic [stt_pkg::TIME_W-1:0]     next_q;

  stt_pkg::cell_ctrl_t ctrl;
  logic accept, wb_go;

  logic [D-1:0]                 lt, q, eq, first, valid;
  logic [stt_pkg::TIME_W-1:0]   val   [D];
  logic [stt_pkg::TIME_W-1:0]   selv  [D];
  logic [stt_pkg::TIME_W-1:0]   next_d;
  logic                         found_d, dup, neg, full, do_ins;

  assign accept = in_valid_i && in_ready_o;
  assign wb_go  = (state_q == stt_pkg::S_WB) && (!out_valid_q || out_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      stt_pkg::S_IDLE: if (in_valid_i) state_d = stt_pkg::S_CMP;
      stt_pkg::S_CMP:  state_d = stt_pkg::S_WB;
      stt_pkg::S_WB:   if (!out_valid_q || out_ready_i) state_d = stt_pkg::S_IDLE;
      default:         state_d = stt_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    ctrl.cmp_en = 1'b0;
    case (state_q)
      stt_pkg::S_IDLE: in_ready_o  = 1'b1;
      stt_pkg::S_CMP:  ctrl.cmp_en = 1'b1;
      stt_pkg::S_WB:   ;
      default:         ;
    endcase
    ctrl.ins_en = wb_go && do_ins;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stt_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (wb_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      opcode_q          <= opcode_i;
      item_q.new_time   <= new_time_i;
      item_q.key_new    <= new_time_i ^ stt_pkg::SIGN_BIT;
      item_q.key_now    <= current_time_i ^ stt_pkg::SIGN_BIT;
      item_q.key_last   <= last_trigger_time_i ^ stt_pkg::SIGN_BIT;
    end
    if (wb_go) begin
      status_q <= status_d;
      found_q  <= found_d;
      next_q   <= next_d;
    end
  end

  // Cell row. Cell 0 has nothing below it, so it counts as the insert point
  // whenever its own time is not below the new one.
  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                         prev_lt, prev_q;
    logic [stt_pkg::TIME_W-1:0]   prev_val;

    assign valid[i] = (stt_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_first
      assign prev_lt  = 1'b1;
      assign prev_q   = 1'b0;
      assign prev_val = '0;
    end else begin : g_rest
      assign prev_lt  = lt[i-1];
      assign prev_q   = q[i-1];
      assign prev_val = val[i-1];
    end

    stt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .item_i     (item_q),
      .valid_i    (valid[i]),
      .prev_lt_i  (prev_lt),
      .prev_q_i   (prev_q),
      .prev_val_i (prev_val),
      .val_o      (val[i]),
      .lt_o       (lt[i]),
      .q_o        (q[i]),
      .eq_o       (eq[i]),
      .first_o    (first[i]),
      .sel_val_o  (selv[i])
    );
  end

  // Qualifying cells form a run at the top of the filled part, so exactly one
  // cell at most flags itself first and the OR below picks its time.
  always_comb begin
    next_d = '0;
    for (int unsigned k = 0; k < D; k++) begin
      next_d = next_d | selv[k];
    end
  end

  always_comb begin
    dup      = |eq;
    neg      = item_q.new_time[stt_pkg::TIME_W-1];
    full     = (count_q == stt_pkg::CNT_W'(D));
    do_ins   = 1'b0;
    status_d = stt_pkg::STAT_OK;
    found_d  = 1'b0;
    count_d  = count_q;
    if (opcode_q == stt_pkg::OP_INSERT) begin
      if (neg) begin
        status_d = stt_pkg::STAT_NEG;
      end else if (dup) begin
        status_d = stt_pkg::STAT_DUP;
      end else if (full) begin
        status_d = stt_pkg::STAT_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end else begin
      found_d = |first;
    end
    if (wb_go && do_ins) begin
      count_d = count_q + stt_pkg::CNT_W'(1);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign next_found_o  = found_q;
  assign next_time_o   = found_q ? next_q : '0;
  assign entry_count_o = stt_pkg::ENTRY_W'(count_q);

endmodule

// ----- bench/trigger_table_checker.sv -----
// Checker for the sorted trigger time table: mirrors the table and compares every result word.
module trigger_table_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic                               opcode_i,
  input  logic signed [stt_pkg::TIME_W-1:0]  new_time_i,
  input  logic signed [stt_pkg::TIME_W-1:0]  current_time_i,
  input  logic signed [stt_pkg::TIME_W-1:0]  last_trigger_time_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic [stt_pkg::STATUS_W-1:0]       status_i,
  input  logic                               next_found_i,
  input  logic signed [stt_pkg::TIME_W-1:0]  next_time_i,
  input  logic [stt_pkg::ENTRY_W-1:0]        entry_count_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  typedef struct packed {
    logic [stt_pkg::STATUS_W-1:0]      status;
    logic                              found;
    logic signed [stt_pkg::TIME_W-1:0] next_time;
    logic [stt_pkg::ENTRY_W-1:0]       count;
  } trigger_result_t;

  trigger_result_t                   expected_q[$];
  logic signed [stt_pkg::TIME_W-1:0] shadow_times [stt_pkg::TABLE_DEPTH];
  int                                shadow_fill;
  int                                fail_total;

  // Applies one word to the shadow table and returns the result word it must produce.
  function automatic trigger_result_t apply_word(
    input logic                              op,
    input logic signed [stt_pkg::TIME_W-1:0] t_new,
    input logic signed [stt_pkg::TIME_W-1:0] t_now,
    input logic signed [stt_pkg::TIME_W-1:0] t_last);
    trigger_result_t r;
    int              pos;
    r = '0;
    if (op == stt_pkg::OP_INSERT) begin
      if (t_new < 0) begin
        r.status = stt_pkg::STAT_NEG;
      end else begin
        // Scanning downward leaves pos at the first entry not below the new time.
        pos = shadow_fill;
        for (int i = shadow_fill - 1; i >= 0; i--) begin
          if (shadow_times[i] >= t_new) pos = i;
        end
        if (pos < shadow_fill && shadow_times[pos] == t_new) begin
          r.status = stt_pkg::STAT_DUP;
        end else if (shadow_fill >= stt_pkg::TABLE_DEPTH) begin
          r.status = stt_pkg::STAT_FULL;
        end else begin
          for (int j = shadow_fill; j > pos; j--) shadow_times[j] = shadow_times[j-1];
          shadow_times[pos] = t_new;
          shadow_fill++;
          r.status = stt_pkg::STAT_OK;
        end
      end
    end else begin
      for (int i = shadow_fill - 1; i >= 0; i--) begin
        if (shadow_times[i] >= t_now && shadow_times[i] > t_last) begin
          r.found     = 1'b1;
          r.next_time = shadow_times[i];
        end
      end
    end
    r.count = stt_pkg::ENTRY_W'(shadow_fill);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    trigger_result_t seen;
    trigger_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      shadow_fill  = 0;
      fail_total   = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_q.insert(expected_q.size(),
                          apply_word(opcode_i, new_time_i, current_time_i,
                                     last_trigger_time_i));
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{status_i, next_found_i, next_time_i, entry_count_i};
        if (expected_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10) begin
            $display("unexpected result word: status=%0d found=%0b time=%h count=%0d",
                     seen.status, seen.found, seen.next_time, seen.count);
          end
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fail_total++;
            if (fail_total <= 10) begin
              $display("result mismatch: expected status=%0d found=%0b time=%h count=%0d",
                       want.status, want.found, want.next_time, want.count);
              $display("                 actual   status=%0d found=%0b time=%h count=%0d",
                       seen.status, seen.found, seen.next_time, seen.count);
            end
          end
        end
      end
      fail_count_o <= fail_total;
      pending_o    <= expected_q.size();
    end
  end

endmodule

// ----- bench/sorted_trigger_time_table_tb.sv -----
// Testbench top for the sorted trigger time table: stimulus, flow control and verdict.
module sorted_trigger_time_table_tb;

  localparam logic signed [stt_pkg::TIME_W-1:0] TIME_MIN =
    {1'b1, {(stt_pkg::TIME_W-1){1'b0}}};
  localparam logic signed [stt_pkg::TIME_W-1:0] TIME_MAX =
    {1'b0, {(stt_pkg::TIME_W-1){1'b1}}};
  localparam logic signed [stt_pkg::TIME_W-1:0] ONE_SEC  = 64'sh1_0000_0000;
  localparam int ITEMS_PER_PHASE = 425;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid;
  logic                               in_ready;
  logic                               opcode;
  logic signed [stt_pkg::TIME_W-1:0]  new_time;
  logic signed [stt_pkg::TIME_W-1:0]  current_time;
  logic signed [stt_pkg::TIME_W-1:0]  last_trigger;
  logic                               out_valid;
  logic                               out_ready;
  logic [stt_pkg::STATUS_W-1:0]       status;
  logic                               next_found;
  logic signed [stt_pkg::TIME_W-1:0]  next_time;
  logic [stt_pkg::ENTRY_W-1:0]        entry_count;

  int mismatch_total;
  int results_pending;
  int tx_idle_pct;
  int rx_stall_pct;
  bit rx_hold_req;

  sorted_trigger_time_table i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .opcode_i            (opcode),
    .new_time_i          (new_time),
    .current_time_i      (current_time),
    .last_trigger_time_i (last_trigger),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .status_o            (status),
    .next_found_o        (next_found),
    .next_time_o         (next_time),
    .entry_count_o       (entry_count)
  );

  trigger_table_checker i_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_i          (in_ready),
    .opcode_i            (opcode),
    .new_time_i          (new_time),
    .current_time_i      (current_time),
    .last_trigger_time_i (last_trigger),
    .out_valid_i         (out_valid),
    .out_ready_i         (out_ready),
    .status_i            (status),
    .next_found_i        (next_found),
    .next_time_i         (next_time),
    .entry_count_i       (entry_count),
    .fail_count_o        (mismatch_total),
    .pending_o           (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Most times come from a pool of 200 values so that duplicates, hits and a full table occur.
  function automatic logic signed [stt_pkg::TIME_W-1:0] pick_time();
    logic signed [stt_pkg::TIME_W-1:0] base;
    int                                sel;
    base = {32'($urandom_range(0, 99)), ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h0};
    sel  = $urandom_range(0, 15);
    if (sel <= 8) return base;
    if (sel == 9) return -base - 64'sd1;
    if (sel <= 11) return {$urandom(), $urandom()};
    if (sel == 12) begin
      case ($urandom_range(0, 4))
        0: return TIME_MIN;
        1: return TIME_MAX;
        2: return '0;
        3: return -64'sd1;
        default: return 64'sd1;
      endcase
    end
    return base + $signed(64'($urandom_range(0, 4))) - 64'sd2;
  endfunction

  // Offers one word and returns at the edge where it is taken; valid stays high afterward.
  task automatic send_word(input logic op, input logic signed [stt_pkg::TIME_W-1:0] t_new,
                           input logic signed [stt_pkg::TIME_W-1:0] t_now,
                           input logic signed [stt_pkg::TIME_W-1:0] t_last);
    @(negedge clk_i);
    while ($urandom_range(1, 100) <= tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    new_time     <= t_new;
    current_time <= t_now;
    last_trigger <= t_last;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_random();
    logic                              op;
    logic signed [stt_pkg::TIME_W-1:0] t_now;
    logic signed [stt_pkg::TIME_W-1:0] t_last;
    op    = ($urandom_range(0, 99) < 40) ? stt_pkg::OP_INSERT : stt_pkg::OP_QUERY;
    t_now = pick_time();
    case ($urandom_range(0, 3))
      0: t_last = t_now - 64'sd1;
      1: t_last = t_now;
      default: t_last = pick_time();
    endcase
    send_word(op, pick_time(), t_now, t_last);
  endtask

  // Holds the sender back until every outstanding result word has been taken.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
  endtask

  initial begin : receiver
    int k;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        for (k = 0; k < 60; k++) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else begin
        out_ready <= (rx_stall_pct == 0) || ($urandom_range(1, 100) > rx_stall_pct);
      end
    end
  end

  initial begin : stimulus
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    opcode       = stt_pkg::OP_QUERY;
    new_time     = '0;
    current_time = '0;
    last_trigger = '0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_req  = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, zero, negatives, the extremes, duplicates and strictness of the last time.
    send_word(stt_pkg::OP_QUERY,  '0, '0, TIME_MIN);
    send_word(stt_pkg::OP_INSERT, '0, '0, '0);
    send_word(stt_pkg::OP_INSERT, '0, '0, '0);
    send_word(stt_pkg::OP_INSERT, -64'sd1, '0, '0);
    send_word(stt_pkg::OP_INSERT, TIME_MIN, '0, '0);
    send_word(stt_pkg::OP_INSERT, TIME_MAX, '0, '0);
    send_word(stt_pkg::OP_INSERT, 64'sd1, '0, '0);
    send_word(stt_pkg::OP_INSERT, 5 * ONE_SEC, '0, '0);
    send_word(stt_pkg::OP_INSERT, 5 * ONE_SEC + 1, '0, '0);
    send_word(stt_pkg::OP_QUERY,  '0, TIME_MIN, TIME_MIN);
    send_word(stt_pkg::OP_QUERY,  '0, '0, '0);
    send_word(stt_pkg::OP_QUERY,  '0, TIME_MAX, TIME_MIN);
    send_word(stt_pkg::OP_QUERY,  '0, 64'sd1, TIME_MAX);
    send_word(stt_pkg::OP_QUERY,  '0, 64'sd2, -64'sd1);
    send_word(stt_pkg::OP_QUERY,  '0, TIME_MAX, TIME_MAX);
    send_word(stt_pkg::OP_INSERT, 64'sd3, '0, '0);
    send_word(stt_pkg::OP_QUERY,  '0, -64'sd1, '0);
    send_word(stt_pkg::OP_QUERY,  '0, 5 * ONE_SEC, 5 * ONE_SEC);
    send_word(stt_pkg::OP_INSERT, TIME_MAX, '0, '0);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
        default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // A long receiver hold-off while words keep coming fills the block and stalls its input.
        if (phase == 0 && n == ITEMS_PER_PHASE / 2) rx_hold_req = 1'b1;
        send_random();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("sorted_trigger_time_table regression: pass");
    end else begin
      $display("sorted_trigger_time_table regression: fail");
    end
    $finish;
  end

  // Well beyond the slowest correct run of about 1700 words with heavy idling on either side.
  initial begin
    #5_000_000;
    $display("sorted_trigger_time_table regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
src/stt_pkg.sv
src/stt_cell.sv
src/sorted_trigger_time_table.sv
bench/trigger_table_checker.sv
bench/sorted_trigger_time_table_tb.sv
